[sv/obv_pkg.sv]
// ----------------------------------------------------------------------------
// obv_pkg
// Shared types and constants for the OSC bundle validator: beat payloads,
// parse phases and the bundle tag table.
// ----------------------------------------------------------------------------
`default_nettype none

package obv_pkg;

    // Default sizing
    localparam int unsigned MAX_DEPTH_DEF        = 8;
    localparam int unsigned MAX_PACKET_BYTES_DEF = 65536;

    // Format constants
    localparam int unsigned TAG_LEN        = 8;
    localparam int unsigned SIZE_LEN       = 4;
    localparam int unsigned MIN_BUNDLE_LEN = 16;
    localparam logic [7:0]  CH_HASH        = 8'h23;  // '#'
    localparam logic [7:0]  CH_SLASH       = 8'h2F;  // '/'
    localparam logic [1:0]  ALIGN_MASK     = 2'h3;

    // Parse phase
    typedef enum logic [2:0] {
        PH_TAG,
        PH_TIME,
        PH_SIZE,
        PH_FIRST,
        PH_BODY
    } t_phase;

    // Input beat: one packet byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_beat;

    // Output beat: one verdict per packet
    typedef struct packed {
        logic valid_res;
        logic depth_exceeded;
    } t_out_beat;

    // "#bundle\0"
    function automatic logic [7:0] f_tag_byte(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h23;
            3'd1:    ch = 8'h62;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h64;
            3'd5:    ch = 8'h6C;
            3'd6:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[sv/obv_parser.sv]
// ----------------------------------------------------------------------------
// obv_parser
// Byte-at-a-time bundle parser. Holds the parse state and the stack of open
// nested-bundle end offsets, and gives the packet verdict on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module obv_parser
    import obv_pkg::*;
#(
    parameter int unsigned MAX_DEPTH        = MAX_DEPTH_DEF,
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_beat  i_beat,
    output t_out_beat      o_res
);

    localparam int unsigned OW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [OW-1:0] MAX_OFF = OW'(MAX_PACKET_BYTES);
    localparam logic [LW-1:0] DEPTH_V = LW'(MAX_DEPTH);

    // State
    logic [OW-1:0] r_off,   n_off;
    t_phase        r_phase, n_phase;
    logic [2:0]    r_cnt,   n_cnt;
    logic [31:0]   r_acc,   n_acc;
    logic [LW-1:0] r_level, n_level;
    logic          r_err,   n_err;
    logic          r_ovf,   n_ovf;
    logic [OW-1:0] r_stack [MAX_DEPTH];
    logic          push;

    // Derived values
    logic [OW-1:0] nxt;
    logic [LW-1:0] lvl_m1;
    logic [SW-1:0] top_idx;
    logic [SW-1:0] push_idx;
    logic [OW-1:0] limit;
    logic [31:0]   sz;
    logic [31:0]   elem_end;
    logic [31:0]   room;
    logic [LW-1:0] pop_level;
    logic          ok;

    assign nxt      = r_off + OW'(1);
    assign lvl_m1   = r_level - LW'(1);
    assign top_idx  = lvl_m1[SW-1:0];
    assign push_idx = r_level[SW-1:0];
    assign limit    = (r_level != '0) ? r_stack[top_idx] : MAX_OFF;
    assign sz       = {r_acc[23:0], i_beat.data_byte};
    assign elem_end = 32'(nxt) + {1'b0, sz[30:0]};
    assign room     = r_acc - 32'(r_off);

    // Close every open bundle whose end is the next offset (top-down run)
    always_comb begin
        pop_level = '0;
        for (int k = 0; k < MAX_DEPTH; k++) begin
            if ((LW'(k) < r_level) && (r_stack[k] != nxt)) begin
                pop_level = LW'(k + 1);
            end
        end
    end

    // Next state for one byte
    always_comb begin
        n_off   = r_off;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_level = r_level;
        n_err   = r_err;
        n_ovf   = r_ovf;
        push    = 1'b0;

        if (!r_err) begin
            if (r_off >= MAX_OFF) begin
                n_err = 1'b1;
            end else begin
                n_off = nxt;
                case (r_phase)
                    PH_TAG: begin
                        if (i_beat.data_byte != f_tag_byte(r_cnt)) begin
                            n_err = 1'b1;
                        end else if (r_cnt == 3'(TAG_LEN - 1)) begin
                            n_phase = PH_TIME;
                            n_cnt   = '0;
                        end else begin
                            n_cnt = r_cnt + 3'd1;
                        end
                    end
                    PH_TIME: begin
                        if (r_cnt == 3'(TAG_LEN - 1)) begin
                            n_level = pop_level;
                            n_phase = PH_SIZE;
                            n_cnt   = '0;
                        end else begin
                            n_cnt = r_cnt + 3'd1;
                        end
                    end
                    PH_SIZE: begin
                        n_acc = sz;
                        if (r_cnt == 3'(SIZE_LEN - 1)) begin
                            if ((sz == '0) || sz[31] || ((sz[1:0] & ALIGN_MASK) != '0)) begin
                                n_err = 1'b1;
                            end else if (elem_end > 32'(limit)) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc   = elem_end;
                                n_phase = PH_FIRST;
                                n_cnt   = '0;
                            end
                        end else begin
                            n_cnt = r_cnt + 3'd1;
                        end
                    end
                    PH_FIRST: begin
                        if (i_beat.data_byte == CH_HASH) begin
                            if (room < 32'(MIN_BUNDLE_LEN)) begin
                                n_err = 1'b1;
                            end else if (r_level >= DEPTH_V) begin
                                n_ovf = 1'b1;
                                n_err = 1'b1;
                            end else begin
                                push    = 1'b1;
                                n_level = r_level + LW'(1);
                                n_phase = PH_TAG;
                                n_cnt   = 3'd1;
                            end
                        end else if (i_beat.data_byte == CH_SLASH) begin
                            if (32'(nxt) == r_acc) begin
                                n_level = pop_level;
                                n_phase = PH_SIZE;
                                n_cnt   = '0;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_BODY: begin
                        if (32'(nxt) == r_acc) begin
                            n_level = pop_level;
                            n_phase = PH_SIZE;
                            n_cnt   = '0;
                        end
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end
        end
    end

    // Verdict from the state after this byte
    assign ok = !n_err && (n_off >= OW'(MIN_BUNDLE_LEN)) && ((n_off[1:0] & ALIGN_MASK) == '0)
                && (n_level == '0) && (n_phase == PH_SIZE) && (n_cnt == '0);

    assign o_res.valid_res      = ok;
    assign o_res.depth_exceeded = n_ovf;

    // Control state; cleared after the last byte of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_phase <= PH_TAG;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_level <= '0;
            r_err   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            if (i_beat.is_last) begin
                r_off   <= '0;
                r_phase <= PH_TAG;
                r_cnt   <= '0;
                r_acc   <= '0;
                r_level <= '0;
                r_err   <= 1'b0;
                r_ovf   <= 1'b0;
            end else begin
                r_off   <= n_off;
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_acc   <= n_acc;
                r_level <= n_level;
                r_err   <= n_err;
                r_ovf   <= n_ovf;
            end
        end
    end

    // End-offset stack; entries at or above the level are never read
    always_ff @(posedge i_clk) begin
        if (i_step && push) begin
            r_stack[push_idx] <= r_acc[OW-1:0];
        end
    end

endmodule

`default_nettype wire

[sv/osc_bundle_validator_unit.sv]
// ----------------------------------------------------------------------------
// osc_bundle_validator_unit
// OSC bundle checker: one packet byte per beat in, one pass/fail beat out
// per packet. Input register, single-pass parser, output register.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle when the input does not stall; the parser
// updates once per byte. The verdict is held in the output register.
// Input stalls only when a last byte waits on a full output register.
// Reset: synchronous, active low; returns the parser to the bundle-tag phase
// with an empty stack and drops both valid flags.
`default_nettype none

module osc_bundle_validator_unit
    import obv_pkg::*;
#(
    parameter int unsigned MAX_DEPTH        = MAX_DEPTH_DEF,
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    logic      r_s_valid;
    t_in_beat  r_s_beat;
    logic      adv;
    t_out_beat res;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    // Stage advances unless a verdict would land on a full output register
    assign adv        = r_s_valid && (!r_s_beat.is_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s_beat <= i_in_beat;
        end
    end

    // Parser
    obv_parser #(
        .MAX_DEPTH        (MAX_DEPTH),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_beat  (r_s_beat),
        .o_res   (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s_beat.is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s_beat.is_last) begin
            r_out_beat <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // Checks
    a_verdict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_beat.valid_res && o_out_beat.depth_exceeded))
        else $error("packet passed with depth exceeded");

    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s_beat.is_last) |=> o_out_valid)
        else $error("last byte produced no verdict beat");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && !adv) |=> (r_s_valid && $stable(r_s_beat)))
        else $error("stalled input stage lost its byte");

endmodule

`default_nettype wire

[bench/tb_osc_bundle_validator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_osc_bundle_validator_unit
// Streams OSC packets into the validator one byte per beat and checks each
// pass/fail verdict. A table of hand-built packets covers the edge cases
// first: bad tags, bad sizes, short and overrun nested bundles, depth limit,
// truncation and the packet-length bound. Random well-formed bundles with
// random content, mixed with corrupted ones and noise, follow. Each expected
// verdict comes from the table or from a bundle-parser model in this bench.
// ----------------------------------------------------------------------------

module tb_osc_bundle_validator_unit;

    import obv_pkg::*;

    typedef logic [7:0] t_bytes [$];

    // Directed packet kinds
    typedef enum {
        K_MIN_BUNDLE,
        K_LONE_BYTE,
        K_BAD_TAG,
        K_MSG_ONES,
        K_MSG_ZEROS,
        K_SIZE_ZERO,
        K_SIZE_NEG,
        K_SIZE_ODD,
        K_SIZE_PAST_END,
        K_BAD_FIRST,
        K_SHORT_NEST,
        K_NEST_OVERRUN,
        K_DEPTH_MAX,
        K_DEPTH_OVER,
        K_OPEN_ELEM,
        K_TIME_CUT,
        K_LEN_ODD,
        K_AFTER_ERR,
        K_NEST_SIBLINGS,
        K_MIXED,
        K_FULL_LEN,
        K_OVER_LEN
    } t_case;

    typedef struct {
        t_case kind;
        bit    typed;   // verdict given below instead of the model's
        bit    ok;
        bit    deep;
    } t_row;

    localparam int          CASE_COUNT   = 22;
    localparam int          HOLD_AT      = CASE_COUNT + 5;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RAND_BYTES   = 750;
    localparam int          RAND_PKTS    = 48;
    localparam int unsigned DEPTH        = MAX_DEPTH_DEF;
    localparam int unsigned PKT_LIMIT    = MAX_PACKET_BYTES_DEF;
    localparam logic [63:0] TAG_WORD     = {"#bundle", 8'h00};
    localparam logic [7:0]  CH_OTHER     = 8'h78;  // 'x'

    t_row case_table [CASE_COUNT] = '{
        '{K_MIN_BUNDLE,    1'b1, 1'b1, 1'b0},
        '{K_LONE_BYTE,     1'b1, 1'b0, 1'b0},
        '{K_BAD_TAG,       1'b1, 1'b0, 1'b0},
        '{K_MSG_ONES,      1'b1, 1'b1, 1'b0},
        '{K_MSG_ZEROS,     1'b0, 1'b0, 1'b0},
        '{K_SIZE_ZERO,     1'b1, 1'b0, 1'b0},
        '{K_SIZE_NEG,      1'b1, 1'b0, 1'b0},
        '{K_SIZE_ODD,      1'b1, 1'b0, 1'b0},
        '{K_SIZE_PAST_END, 1'b1, 1'b0, 1'b0},
        '{K_BAD_FIRST,     1'b1, 1'b0, 1'b0},
        '{K_SHORT_NEST,    1'b1, 1'b0, 1'b0},
        '{K_NEST_OVERRUN,  1'b1, 1'b0, 1'b0},
        '{K_DEPTH_MAX,     1'b1, 1'b1, 1'b0},
        '{K_DEPTH_OVER,    1'b1, 1'b0, 1'b1},
        '{K_OPEN_ELEM,     1'b1, 1'b0, 1'b0},
        '{K_TIME_CUT,      1'b1, 1'b0, 1'b0},
        '{K_LEN_ODD,       1'b1, 1'b0, 1'b0},
        '{K_AFTER_ERR,     1'b1, 1'b0, 1'b0},
        '{K_NEST_SIBLINGS, 1'b0, 1'b0, 1'b0},
        '{K_MIXED,         1'b0, 1'b0, 1'b0},
        '{K_FULL_LEN,      1'b1, 1'b1, 1'b0},
        '{K_OVER_LEN,      1'b1, 1'b0, 1'b0}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_ready = 1'b0;
    wire       in_ready;
    wire       out_valid;
    t_out_beat out_beat;

    t_out_beat verdict_q [$];
    int        mismatches    = 0;
    int        verdicts_seen = 0;
    int        rand_bytes    = 0;
    bit        steady        = 1'b0;

    // Parser model state
    logic [31:0] pos_r;
    t_phase      phase_r;
    int unsigned cnt_r;
    logic [31:0] acc_r;
    logic [31:0] ends_r [DEPTH];
    int unsigned lvl_r;
    bit          err_r;
    bit          ovf_r;

    osc_bundle_validator_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bundle parser model
    // ------------------------------------------------------------------------
    function automatic void clear_parser();
        pos_r   = '0;
        phase_r = PH_TAG;
        cnt_r   = 0;
        acc_r   = '0;
        lvl_r   = 0;
        err_r   = 1'b0;
        ovf_r   = 1'b0;
        foreach (ends_r[i]) ends_r[i] = '0;
    endfunction

    // Pop every nested bundle that ends here, then expect a size field
    function automatic void close_bundles(input logic [31:0] at);
        while (lvl_r > 0 && lvl_r <= DEPTH && ends_r[lvl_r - 1] == at)
            lvl_r--;
        phase_r = PH_SIZE;
        cnt_r   = 0;
    endfunction

    function automatic void feed_parser(input logic [7:0] b);
        logic [31:0] at;
        logic [31:0] nxt;
        logic [31:0] fin;
        logic [31:0] lim;
        int          idx;
        at  = pos_r;
        nxt = pos_r + 32'd1;
        if (at >= PKT_LIMIT) begin
            err_r = 1'b1;
            return;
        end
        pos_r = nxt;
        case (phase_r)
            PH_TAG: begin
                idx = int'(cnt_r & 7);
                if (b != TAG_WORD[63 - 8*idx -: 8]) begin
                    err_r = 1'b1;
                    return;
                end
                cnt_r++;
                if (cnt_r >= TAG_LEN) begin
                    phase_r = PH_TIME;
                    cnt_r   = 0;
                end
            end
            PH_TIME: begin
                cnt_r++;
                if (cnt_r >= TAG_LEN)
                    close_bundles(nxt);
            end
            PH_SIZE: begin
                acc_r = {acc_r[23:0], b};
                cnt_r++;
                if (cnt_r >= SIZE_LEN) begin
                    if (acc_r == 0 || acc_r[31] || (acc_r[1:0] & ALIGN_MASK) != 0) begin
                        err_r = 1'b1;
                        return;
                    end
                    fin = nxt + acc_r;
                    lim = (lvl_r > 0 && lvl_r <= DEPTH) ? ends_r[lvl_r - 1] : PKT_LIMIT;
                    if (fin > lim) begin
                        err_r = 1'b1;
                        return;
                    end
                    acc_r   = fin;
                    phase_r = PH_FIRST;
                    cnt_r   = 0;
                end
            end
            PH_FIRST: begin
                if (b == CH_HASH) begin
                    if (acc_r - at < MIN_BUNDLE_LEN) begin
                        err_r = 1'b1;
                        return;
                    end
                    if (lvl_r >= DEPTH) begin
                        ovf_r = 1'b1;
                        err_r = 1'b1;
                        return;
                    end
                    ends_r[lvl_r] = acc_r;
                    lvl_r++;
                    phase_r = PH_TAG;
                    cnt_r   = 1;
                end else if (b == CH_SLASH) begin
                    if (nxt == acc_r)
                        close_bundles(nxt);
                    else
                        phase_r = PH_BODY;
                end else begin
                    err_r = 1'b1;
                end
            end
            PH_BODY: begin
                if (nxt == acc_r)
                    close_bundles(nxt);
            end
            default: err_r = 1'b1;
        endcase
    endfunction

    // Returns 1 when the beat closes a packet; res holds the verdict
    function automatic bit predict_verdict(input t_in_beat beat, output t_out_beat res);
        res = '0;
        if (!err_r)
            feed_parser(beat.data_byte);
        if (!beat.is_last)
            return 1'b0;
        res.valid_res = !err_r && pos_r >= MIN_BUNDLE_LEN &&
                        (pos_r[1:0] & ALIGN_MASK) == 0 && lvl_r == 0 &&
                        phase_r == PH_SIZE && cnt_r == 0;
        res.depth_exceeded = ovf_r;
        clear_parser();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Packet builders
    // ------------------------------------------------------------------------
    function automatic void push_word(ref t_bytes q, input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            q.push_back(w[31 - 8*i -: 8]);
    endfunction

    // fill < 0 means random bytes
    function automatic void push_fill(ref t_bytes q, input int n, input int fill);
        for (int i = 0; i < n; i++)
            q.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
    endfunction

    function automatic void push_head(ref t_bytes q, input int time_fill);
        for (int i = 0; i < 8; i++)
            q.push_back(TAG_WORD[63 - 8*i -: 8]);
        push_fill(q, 8, time_fill);
    endfunction

    function automatic void push_message(ref t_bytes q, input int words, input int fill);
        push_word(q, 32'(4 * words));
        q.push_back(CH_SLASH);
        push_fill(q, 4 * words - 1, fill);
    endfunction

    function automatic void push_messages(ref t_bytes q, input int n);
        for (int i = 0; i < n; i++)
            push_message(q, $urandom_range(1, 5), -1);
    endfunction

    function automatic void push_element(ref t_bytes q, input t_bytes body);
        push_word(q, 32'(body.size()));
        foreach (body[i]) q.push_back(body[i]);
    endfunction

    // Well-formed bundle with a chain of nest nested bundles, random siblings
    function automatic t_bytes make_bundle(input int nest);
        t_bytes inner;
        t_bytes outer;
        push_head(inner, -1);
        push_messages(inner, $urandom_range(3));
        for (int lvl = 0; lvl < nest; lvl++) begin
            outer.delete();
            push_head(outer, -1);
            push_messages(outer, $urandom_range(2));
            push_element(outer, inner);
            push_messages(outer, $urandom_range(2));
            inner = outer;
        end
        return inner;
    endfunction

    function automatic t_bytes make_case(input t_case k);
        t_bytes q;
        t_bytes inner;
        case (k)
            K_MIN_BUNDLE: push_head(q, -1);
            K_LONE_BYTE:  q.push_back(CH_HASH);
            K_BAD_TAG: begin
                push_head(q, -1);
                q[3] = 8'h4E;
            end
            K_MSG_ONES: begin
                push_head(q, 'hFF);
                push_message(q, 2, 'hFF);
            end
            K_MSG_ZEROS: begin
                push_head(q, 0);
                push_message(q, 3, 0);
            end
            K_SIZE_ZERO: begin
                push_head(q, -1);
                push_word(q, 32'd0);
                push_fill(q, 4, -1);
            end
            K_SIZE_NEG: begin
                push_head(q, -1);
                push_word(q, 32'h8000_0004);
                q.push_back(CH_SLASH);
                push_fill(q, 3, -1);
            end
            K_SIZE_ODD: begin
                push_head(q, -1);
                push_word(q, 32'd6);
                q.push_back(CH_SLASH);
                push_fill(q, 7, -1);
            end
            K_SIZE_PAST_END: begin
                push_head(q, -1);
                push_word(q, 32'(PKT_LIMIT));
                q.push_back(CH_SLASH);
                push_fill(q, 3, -1);
            end
            K_BAD_FIRST: begin
                push_head(q, -1);
                push_word(q, 32'd4);
                q.push_back(CH_OTHER);
                push_fill(q, 3, -1);
            end
            K_SHORT_NEST: begin
                push_head(q, -1);
                push_word(q, 32'd12);
                q.push_back(CH_HASH);
                push_fill(q, 11, -1);
            end
            K_NEST_OVERRUN: begin
                // inner element runs 4 bytes past the nested bundle's end
                push_head(inner, -1);
                push_message(inner, 2, -1);
                push_head(q, -1);
                push_word(q, 32'(inner.size() - 4));
                foreach (inner[i]) q.push_back(inner[i]);
            end
            K_DEPTH_MAX:     q = make_bundle(DEPTH);
            K_DEPTH_OVER:    q = make_bundle(DEPTH + 1);
            K_OPEN_ELEM: begin
                push_head(q, -1);
                push_word(q, 32'd8);
                q.push_back(CH_SLASH);
                push_fill(q, 3, -1);
            end
            K_TIME_CUT: begin
                push_head(q, -1);
                repeat (4) void'(q.pop_back());
            end
            K_LEN_ODD: begin
                push_head(q, -1);
                push_fill(q, 2, -1);
            end
            K_AFTER_ERR: begin
                // a good bundle behind a bad first byte is never looked at
                inner = make_bundle(1);
                q.push_back(8'h00);
                foreach (inner[i]) q.push_back(inner[i]);
            end
            K_NEST_SIBLINGS: q = make_bundle(2);
            K_MIXED:         q = make_bundle(1);
            K_FULL_LEN: begin
                push_head(q, -1);
                push_message(q, (PKT_LIMIT - 20) / 4, -1);
            end
            K_OVER_LEN: begin
                push_head(q, -1);
                push_message(q, (PKT_LIMIT - 20) / 4, -1);
                push_fill(q, 1, -1);
            end
            default: push_head(q, -1);
        endcase
        return q;
    endfunction

    // Mostly well-formed bundles; the rest corrupted, cut, padded or noise
    function automatic t_bytes make_random_packet();
        t_bytes q;
        int     pick;
        int     n;
        pick = $urandom_range(99);
        if (pick < 55) begin
            q = make_bundle($urandom_range(2));
        end else if (pick < 63) begin
            q = make_bundle($urandom_range(3, DEPTH + 1));
        end else if (pick < 73) begin
            q = make_bundle($urandom_range(2));
            q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
        end else if (pick < 81) begin
            q = make_bundle($urandom_range(2));
            n = $urandom_range(1, q.size());
            while (q.size() > n) void'(q.pop_back());
        end else if (pick < 87) begin
            q = make_bundle($urandom_range(2));
            push_fill(q, $urandom_range(1, 8), -1);
        end else if (pick < 93) begin
            // hit a size field of the first element
            q = make_bundle(0);
            push_messages(q, 1);
            q[16 + $urandom_range(3)] = 8'($urandom_range(255));
        end else begin
            if ($urandom_range(1))
                push_head(q, -1);
            push_fill(q, $urandom_range(1, 40), -1);
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    function automatic bit gap_roll();
        return !steady && ($urandom_range(99) < 9);
    endfunction

    task automatic send_beat(input t_in_beat beat, input bit typed, input t_out_beat fixed);
        t_out_beat pred;
        while (gap_roll()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (!in_ready);
        if (predict_verdict(beat, pred))
            verdict_q.push_back(typed ? fixed : pred);
    endtask

    task automatic send_packet(input t_bytes pkt, input bit typed, input t_out_beat fixed);
        t_in_beat beat;
        foreach (pkt[i]) begin
            beat.data_byte = pkt[i];
            beat.is_last   = (i == pkt.size() - 1);
            send_beat(beat, typed, fixed);
            rand_bytes++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (verdict_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_verdict(input t_out_beat got);
        t_out_beat want;
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("verdict %0d with none pending", verdicts_seen));
        end else begin
            want = verdict_q.pop_front();
            if (got.valid_res !== want.valid_res)
                report_mismatch($sformatf("verdict %0d valid_res got %b want %b",
                                          verdicts_seen, got.valid_res, want.valid_res));
            if (got.depth_exceeded !== want.depth_exceeded)
                report_mismatch($sformatf("verdict %0d depth_exceeded got %b want %b",
                                          verdicts_seen, got.depth_exceeded,
                                          want.depth_exceeded));
        end
    endtask

    // Receiver: random stalls plus one long hold-off to back up the block
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready)
                check_verdict(out_beat);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && verdicts_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !gap_roll();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_out_beat fixed;
        clear_parser();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (case_table[r]) begin
            fixed.valid_res      = case_table[r].ok;
            fixed.depth_exceeded = case_table[r].deep;
            send_packet(make_case(case_table[r].kind), case_table[r].typed, fixed);
        end

        // random packets; a quiet stretch with no gaps, one full drain
        rand_bytes = 0;
        for (int n = 0; rand_bytes < RAND_BYTES || n < RAND_PKTS; n++) begin
            steady = (n >= 12 && n < 24);
            if (n == 30)
                wait_drained();
            send_packet(make_random_packet(), 1'b0, '0);
        end
        steady = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
